/* hdl/wpag_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpag_pkg
// Shared types and constants for the weight preshuffle address generator.
// ----------------------------------------------------------------------------
package wpag_pkg;

    localparam int CFG_W    = 14;
    localparam int LG_W     = 3;
    localparam int K0_W     = 10;
    localparam int OFS_W    = 10;
    localparam int BLK_W    = 16;
    localparam int ADDR_W   = 26;
    localparam int DATA_W   = 8;
    localparam int IDX_W    = 2;
    localparam int LANE_W   = 6;
    localparam int SHIFT_W  = 4;

    localparam int MAX_ROWS_DEF = 8192;
    localparam int MAX_COLS_DEF = 8192;

    localparam logic [CFG_W-1:0] ROW_COUNT_RST = CFG_W'(1024);
    localparam logic [CFG_W-1:0] COL_COUNT_RST = CFG_W'(1024);
    localparam logic [LG_W-1:0]  LANE_LOG2_RST = LG_W'(5);
    localparam logic [LG_W-1:0]  LANE_LOG2_MAX = LG_W'(6);
    localparam logic [LG_W-1:0]  LANE_LOG2_BAD = LG_W'(7);

    // log2 of the 1024-element block
    localparam logic [SHIFT_W-1:0] BLK_LOG2 = SHIFT_W'(10);
    // log2 of the 16-element pack
    localparam int KPACK_LOG2 = 4;

    typedef enum logic [IDX_W-1:0] {
        REG_ROW_COUNT = 2'd0,
        REG_COL_COUNT = 2'd1,
        REG_LANE_LOG2 = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [CFG_W-1:0] rows;
        logic [CFG_W-1:0] cols;
        logic [LG_W-1:0]  lg;
        logic [K0_W-1:0]  k0cnt;
    } t_cfg;

endpackage

/* hdl/wpag_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpag_cfg_regs
// Configuration registers and the effective (clamped) matrix geometry.
// ----------------------------------------------------------------------------
module wpag_cfg_regs #(
    parameter int MAX_ROWS = wpag_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = wpag_pkg::MAX_COLS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [wpag_pkg::IDX_W-1:0] i_cfg_idx,
    input  logic [wpag_pkg::CFG_W-1:0] i_cfg_data,
    output wpag_pkg::t_cfg             o_cfg
);
    import wpag_pkg::*;

    logic [CFG_W-1:0]   r_row_count;
    logic [CFG_W-1:0]   r_col_count;
    logic [LG_W-1:0]    r_lane_log2;
    logic [CFG_W-1:0]   rows;
    logic [CFG_W-1:0]   cols;
    logic [LG_W-1:0]    lg;
    logic [SHIFT_W-1:0] blk_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= ROW_COUNT_RST;
            r_col_count <= COL_COUNT_RST;
            r_lane_log2 <= LANE_LOG2_RST;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_ROW_COUNT: r_row_count <= i_cfg_data;
                REG_COL_COUNT: r_col_count <= i_cfg_data;
                REG_LANE_LOG2: r_lane_log2 <= i_cfg_data[LG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_row_count == '0) begin
            rows = CFG_W'(1);
        end else if (32'(r_row_count) > MAX_ROWS) begin
            rows = CFG_W'(MAX_ROWS);
        end else begin
            rows = r_row_count;
        end
        if (r_col_count == '0) begin
            cols = CFG_W'(1);
        end else if (32'(r_col_count) > MAX_COLS) begin
            cols = CFG_W'(MAX_COLS);
        end else begin
            cols = r_col_count;
        end
        lg     = (r_lane_log2 == LANE_LOG2_BAD) ? LANE_LOG2_MAX : r_lane_log2;
        blk_sh = BLK_LOG2 - SHIFT_W'(lg);
    end

    assign o_cfg.rows  = rows;
    assign o_cfg.cols  = cols;
    assign o_cfg.lg    = lg;
    assign o_cfg.k0cnt = K0_W'(cols >> blk_sh);

endmodule

/* hdl/wpag_index_ctr.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpag_index_ctr
// Row and column position of the next source element, with wrap at the end.
// ----------------------------------------------------------------------------
module wpag_index_ctr #(
    parameter int ROW_W = 13,
    parameter int COL_W = 13
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  wpag_pkg::t_cfg    i_cfg,
    output logic [ROW_W-1:0]  o_row,
    output logic [COL_W-1:0]  o_col,
    output logic              o_last
);
    import wpag_pkg::*;

    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] n_row;
    logic [COL_W-1:0] n_col;
    logic [CFG_W:0]   row_inc;
    logic [CFG_W:0]   col_inc;
    logic             row_end;
    logic             col_end;

    always_comb begin
        row_inc = (CFG_W+1)'(r_row) + (CFG_W+1)'(1);
        col_inc = (CFG_W+1)'(r_col) + (CFG_W+1)'(1);
        row_end = row_inc >= {1'b0, i_cfg.rows};
        col_end = col_inc >= {1'b0, i_cfg.cols};
        n_row   = r_row;
        n_col   = r_col;
        if (i_adv) begin
            if (col_end) begin
                n_col = '0;
                n_row = row_end ? '0 : ROW_W'(row_inc);
            end else begin
                n_col = COL_W'(col_inc);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    assign o_row  = r_row;
    assign o_col  = r_col;
    assign o_last = row_end && col_end;

endmodule

/* hdl/wpag_addr_calc.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpag_addr_calc
// Shuffled destination address of element (n, k): block index times 1024
// plus the offset inside the block.
// ----------------------------------------------------------------------------
module wpag_addr_calc #(
    parameter int ROW_W = 13,
    parameter int COL_W = 13
) (
    input  logic [ROW_W-1:0]            i_row,
    input  logic [COL_W-1:0]            i_col,
    input  wpag_pkg::t_cfg              i_cfg,
    output logic [wpag_pkg::ADDR_W-1:0] o_addr
);
    import wpag_pkg::*;

    logic [CFG_W-1:0]          nx;
    logic [CFG_W-1:0]          kx;
    logic [SHIFT_W-1:0]        blk_sh;
    logic [OFS_W-1:0]          kt_mask;
    logic [OFS_W-1:0]          kt;
    logic [LANE_W:0]           lane_mask;
    logic [LANE_W-1:0]         n1;
    logic [OFS_W-1:0]          k1_part;
    logic [OFS_W-1:0]          ofs;
    logic [CFG_W-1:0]          n0;
    logic [CFG_W-1:0]          k0;
    logic [CFG_W+K0_W-1:0]     prod;
    logic [BLK_W-1:0]          blk;

    always_comb begin
        nx        = CFG_W'(i_row);
        kx        = CFG_W'(i_col);
        blk_sh    = BLK_LOG2 - SHIFT_W'(i_cfg.lg);
        kt_mask   = {OFS_W{1'b1}} >> i_cfg.lg;
        kt        = kx[OFS_W-1:0] & kt_mask;
        lane_mask = ((LANE_W+1)'(1) << i_cfg.lg) - (LANE_W+1)'(1);
        n1        = nx[LANE_W-1:0] & lane_mask[LANE_W-1:0];
        // k1 * 16 * NLane, with k1 = kt / 16
        k1_part   = (kt >> KPACK_LOG2) << (SHIFT_W'(KPACK_LOG2) + SHIFT_W'(i_cfg.lg));
        ofs       = k1_part | (OFS_W'(n1) << KPACK_LOG2) | OFS_W'(kt[KPACK_LOG2-1:0]);
        n0        = nx >> i_cfg.lg;
        k0        = kx >> blk_sh;
        prod      = (CFG_W+K0_W)'(n0) * (CFG_W+K0_W)'(i_cfg.k0cnt);
        blk       = prod[BLK_W-1:0] + BLK_W'(k0);
    end

    assign o_addr = {blk, ofs};

endmodule

/* hdl/weight_preshuffle_address_gen.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weight_preshuffle_address_gen
// Streams a row-major matrix one element per beat and tags each element with
// its index in the shuffled weight layout and an end-of-matrix flag.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  input    | i_valid / o_stall    | i_elem_data
//  output   | o_valid / i_stall    | o_dest_addr, o_dest_data, o_is_last
//  config   | i_cfg_we             | i_cfg_idx, i_cfg_data
//
//  one beat per cycle sustained while the output is not stalled; a taken beat
//  passes the position register, then the address multiply into the output
//  register
//  reset is synchronous, active low; counters restart at row 0, column 0
//  an output stall backs up through both stages to o_stall in the same cycle
// ----------------------------------------------------------------------------
module weight_preshuffle_address_gen #(
    parameter int MAX_ROWS = wpag_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = wpag_pkg::MAX_COLS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [wpag_pkg::IDX_W-1:0]  i_cfg_idx,
    input  logic [wpag_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [wpag_pkg::DATA_W-1:0] i_elem_data,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [wpag_pkg::ADDR_W-1:0] o_dest_addr,
    output logic [wpag_pkg::DATA_W-1:0] o_dest_data,
    output logic                        o_is_last
);
    import wpag_pkg::*;

    localparam int ROW_W = ($clog2(MAX_ROWS) > CFG_W) ? CFG_W : $clog2(MAX_ROWS);
    localparam int COL_W = ($clog2(MAX_COLS) > CFG_W) ? CFG_W : $clog2(MAX_COLS);

    t_cfg              cfg;
    logic [ROW_W-1:0]  cur_row;
    logic [COL_W-1:0]  cur_col;
    logic              cur_last;
    logic [ADDR_W-1:0] addr;

    logic              out_ready;
    logic              s1_ready;
    logic              in_acc;
    logic              s1_mv;

    logic              r_s1_v;
    logic [ROW_W-1:0]  r_s1_row;
    logic [COL_W-1:0]  r_s1_col;
    logic [DATA_W-1:0] r_s1_data;
    logic              r_s1_last;
    logic              n_s1_v;

    logic              r_out_v;
    logic [ADDR_W-1:0] r_out_addr;
    logic [DATA_W-1:0] r_out_data;
    logic              r_out_last;
    logic              n_out_v;

    wpag_cfg_regs #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    wpag_index_ctr #(
        .ROW_W (ROW_W),
        .COL_W (COL_W)
    ) u_ctr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (in_acc),
        .i_cfg   (cfg),
        .o_row   (cur_row),
        .o_col   (cur_col),
        .o_last  (cur_last)
    );

    wpag_addr_calc #(
        .ROW_W (ROW_W),
        .COL_W (COL_W)
    ) u_addr (
        .i_row  (r_s1_row),
        .i_col  (r_s1_col),
        .i_cfg  (cfg),
        .o_addr (addr)
    );

    always_comb begin
        out_ready = !r_out_v || !i_stall;
        s1_ready  = !r_s1_v || out_ready;
        in_acc    = i_valid && s1_ready;
        s1_mv     = r_s1_v && out_ready;
        n_s1_v    = in_acc ? 1'b1 : (s1_mv ? 1'b0 : r_s1_v);
        n_out_v   = s1_mv ? 1'b1 : (out_ready ? 1'b0 : r_out_v);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_s1_v  <= n_s1_v;
            r_out_v <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_row  <= cur_row;
            r_s1_col  <= cur_col;
            r_s1_data <= i_elem_data;
            r_s1_last <= cur_last;
        end
        if (s1_mv) begin
            r_out_addr <= addr;
            r_out_data <= r_s1_data;
            r_out_last <= r_s1_last;
        end
    end

    assign o_stall     = !s1_ready;
    assign o_valid     = r_out_v;
    assign o_dest_addr = r_out_addr;
    assign o_dest_data = r_out_data;
    assign o_is_last   = r_out_last;

    // counters restart after the last element of the matrix
    a_wrap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && cur_last) |=> (cur_row == '0 && cur_col == '0))
        else $error("position counters did not wrap after last element");

    // the input side only stalls while both stages hold a beat
    a_stall_needs_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_s1_v && r_out_v))
        else $error("input stalled with an empty pipeline stage");

    // a held first-stage beat is not dropped while the output is blocked
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && r_out_v && i_stall) |=> (r_s1_v && r_out_v))
        else $error("beat lost while output stalled");

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the weight preshuffle address generator.
//
// A queue of source elements feeds a clocked driver. On every accepted beat an
// in-bench address predictor, with its own row/column counters and register
// shadows, works out the shuffled destination index, the passed-through data
// and the end-of-matrix flag. A clocked monitor takes output beats and compares
// them field by field with the oldest prediction. Register settings change
// only while the block is drained: zero and oversized counts, lane code seven,
// column counts that do not fill a block and counts shrunk mid-matrix are
// covered first, then random matrices under several idle/stall mixes, then a
// long output hold that backs the block up.
// ----------------------------------------------------------------------------
module tb;
    import wpag_pkg::*;

    localparam int WAVE  = 64;
    localparam int KPACK = 1 << KPACK_LOG2;
    localparam int BLK   = 1 << BLK_LOG2;
    localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic              last;
    } t_dest_beat;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_we    = 1'b0;
    logic [IDX_W-1:0]  i_cfg_idx   = '0;
    logic [CFG_W-1:0]  i_cfg_data  = '0;
    logic              i_valid     = 1'b0;
    logic [DATA_W-1:0] i_elem_data = '0;
    logic              i_stall     = 1'b0;
    logic              o_stall;
    logic              o_valid;
    logic [ADDR_W-1:0] o_dest_addr;
    logic [DATA_W-1:0] o_dest_data;
    logic              o_is_last;

    weight_preshuffle_address_gen i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_elem_data (i_elem_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_dest_addr (o_dest_addr),
        .o_dest_data (o_dest_data),
        .o_is_last   (o_is_last)
    );

    logic [DATA_W-1:0] elem_q[$];
    t_dest_beat        dest_q[$];

    logic [CFG_W-1:0] sh_rows = ROW_COUNT_RST;
    logic [CFG_W-1:0] sh_cols = COL_COUNT_RST;
    logic [LG_W-1:0]  sh_lg   = LANE_LOG2_RST;
    int unsigned      sh_row  = 0;
    int unsigned      sh_col  = 0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;

    int n_sent = 0;
    int n_recv = 0;
    int n_last = 0;
    int n_cfg = 0;
    int n_err = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // destination index of the element at the current position, then advance
    function automatic t_dest_beat shuffled_beat(input logic [DATA_W-1:0] d);
        longint unsigned rows, cols, lg, nlane, kblock, k0cnt, n, k, addr;
        t_dest_beat r;
        rows = (sh_rows == 0) ? 1 : (sh_rows > MAX_ROWS_DEF) ? MAX_ROWS_DEF : sh_rows;
        cols = (sh_cols == 0) ? 1 : (sh_cols > MAX_COLS_DEF) ? MAX_COLS_DEF : sh_cols;
        lg = (sh_lg > LANE_LOG2_MAX) ? LANE_LOG2_MAX : sh_lg;
        nlane = 1 << lg;
        kblock = (WAVE >> lg) * KPACK;
        k0cnt = cols / kblock;
        n = sh_row;
        k = sh_col;
        addr = (n >> lg) * BLK * k0cnt + (k / kblock) * BLK
             + ((k % kblock) / KPACK) * KPACK * nlane + (n % nlane) * KPACK + k % KPACK;
        r.addr = addr[ADDR_W-1:0];
        r.data = d;
        r.last = (k + 1 >= cols) && (n + 1 >= rows);
        if (k + 1 >= cols) begin
            sh_col = 0;
            sh_row = (n + 1 >= rows) ? 0 : int'(n + 1);
        end else begin
            sh_col = int'(k + 1);
        end
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            sh_rows = ROW_COUNT_RST;
            sh_cols = COL_COUNT_RST;
            sh_lg = LANE_LOG2_RST;
            sh_row = 0;
            sh_col = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ROW_COUNT: sh_rows = i_cfg_data;
                    REG_COL_COUNT: sh_cols = i_cfg_data;
                    REG_LANE_LOG2: sh_lg = i_cfg_data[LG_W-1:0];
                    default: ;
                endcase
            end
            if (i_valid && !o_stall) begin
                dest_q.push_back(shuffled_beat(i_elem_data));
                n_sent++;
            end
            if (i_valid && o_stall) begin
                // stalled beat holds
            end else if (elem_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_valid <= 1'b1;
                i_elem_data <= elem_q.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    task automatic report(input string what, input int unsigned e, input int unsigned a);
        n_err++;
        if (n_err <= 30)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, e, a);
    endtask

    // monitor
    always @(posedge i_clk) begin : monitor
        t_dest_beat exp_beat;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (dest_q.size() == 0) begin
                    report("unexpected beat, dest_addr", 0, o_dest_addr);
                end else begin
                    exp_beat = dest_q.pop_front();
                    if (o_dest_addr !== exp_beat.addr)
                        report("dest_addr", exp_beat.addr, o_dest_addr);
                    if (o_dest_data !== exp_beat.data)
                        report("dest_data", exp_beat.data, o_dest_data);
                    if (o_is_last !== exp_beat.last)
                        report("is_last", exp_beat.last, o_is_last);
                    n_recv++;
                    if (exp_beat.last)
                        n_last++;
                end
            end
            if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            end
        end
    end

    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (elem_q.size() != 0 || i_valid || dest_q.size() != 0);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        n_cfg++;
    endtask

    task automatic apply_config(input int unsigned rows, input int unsigned cols,
                                input int unsigned lg);
        wait_idle();
        write_reg(REG_ROW_COUNT, CFG_W'(rows));
        write_reg(REG_COL_COUNT, CFG_W'(cols));
        write_reg(REG_LANE_LOG2, {(CFG_W-LG_W)'($urandom), LG_W'(lg)});
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic push_random(input int cnt);
        repeat (cnt) elem_q.push_back(DATA_W'($urandom_range(0, 255)));
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
            default: begin send_idle_pct = 28; recv_stall_pct = 28; end
        endcase
    endtask

    function automatic int unsigned pick_count();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return $urandom_range(MAX_ROWS_DEF, (1 << CFG_W) - 1);
            2: return KPACK * $urandom_range(1, 16);
            default: return $urandom_range(1, 40);
        endcase
    endfunction

    initial begin : stimulus
        int ph;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset defaults, data extremes
        elem_q.push_back(8'h00);
        elem_q.push_back(8'hFF);
        elem_q.push_back(8'hAA);
        elem_q.push_back(8'h55);

        // unused register index, zero counts and lane code seven
        wait_idle();
        write_reg(REG_SPARE, '1);
        apply_config(0, 0, 7);
        push_random(3);

        // oversized counts saturate
        apply_config((1 << CFG_W) - 1, (1 << CFG_W) - 1, 6);
        push_random(3);

        // walk rows, then shrink the row count below the current row
        apply_config(8, 1, 1);
        push_random(5);
        apply_config(2, 1, 1);
        push_random(2);

        // column count short of one block, then shrunk mid-row
        apply_config(3, 40, 2);
        push_random(6);
        apply_config(3, 4, 2);
        push_random(1);

        for (ph = 0; ph < 11; ph++) begin
            wait_idle();
            set_idling(ph % 4);
            if (ph == 0)
                apply_config(1, 1, 0);
            else if (ph == 1)
                apply_config(MAX_ROWS_DEF, MAX_COLS_DEF, 6);
            else
                apply_config(pick_count(), pick_count(), $urandom_range(0, 7));
            push_random(150);
        end

        // long output hold while the sender keeps offering
        set_idling(0);
        apply_config(4, 32, 3);
        push_random(100);
        hold_req++;
        // sender pauses until the block has drained
        wait_idle();
        push_random(100);

        wait_idle();
        repeat (10) @(posedge i_clk);
        $display("streamed %0d elements through %0d register writes", n_sent, n_cfg);
        $display("checked %0d output beats, %0d of them end-of-matrix", n_recv, n_last);
        if (n_err == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
